// ----- hw/rtl/escal_pkg.sv -----
// Shared types, constants and calendar helpers for the epoch-to-calendar block.
package escal_pkg;

    localparam int EPOCH_W = 32;
    localparam int ALU_W   = 16;
    localparam int REM_W   = 6;
    localparam int STEP_W  = 1;

    localparam logic [REM_W-1:0] SEC_PER_MIN   = 6'd60;
    localparam logic [REM_W-1:0] MIN_PER_HOUR  = 6'd60;
    localparam logic [REM_W-1:0] HOUR_PER_DAY  = 6'd24;
    localparam logic [REM_W-1:0] DAYS_PER_WEEK = 6'd7;

    localparam logic [ALU_W-1:0] DAYS_YEAR     = 16'd365;
    localparam logic [ALU_W-1:0] DAYS_LEAP     = 16'd366;
    localparam logic [ALU_W-1:0] WDAY_OFFSET   = 16'd4;

    // Exact reciprocals: n / 60 = (n * RECIP_60) >> 37 and n / 24 = (n * RECIP_24) >> 36
    // for any 32-bit n; n / 7 = (n * RECIP_7) >> 19 for n below 2^16
    localparam logic [EPOCH_W-1:0] RECIP_60 = 32'h8888_8889;
    localparam logic [EPOCH_W-1:0] RECIP_24 = 32'hAAAA_AAAB;
    localparam logic [EPOCH_W-1:0] RECIP_7  = 32'h0001_2493;

    localparam logic [7:0] YEAR_EPOCH          = 8'd70;
    // 2100 is the only century year in range that is not leap (2000 is)
    localparam logic [7:0] YEAR_NOLEAP_CENTURY = 8'd200;

    localparam logic [3:0] MONTH_FEB = 4'd1;

    // Each division pass: multiply cycle, then quotient and remainder cycle
    localparam logic [STEP_W-1:0] DIV_LAST_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_SEC,
        ST_DIV_MIN,
        ST_DIV_HOUR,
        ST_DIV_WDAY,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        state_t state;
        logic   last_step;
        logic   load_out;
    } ctrl_t;

    typedef struct packed {
        logic ge;
    } status_t;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic [7:0] year_since_1900;
        logic [2:0] day_of_week;
        logic [8:0] day_of_year;
    } result_t;

    // Years since 1900; exact for 1901..2155
    function automatic logic is_leap(input logic [7:0] year);
        is_leap = (year[1:0] == 2'b00) && (year != YEAR_NOLEAP_CENTURY);
    endfunction

    function automatic logic [4:0] days_in_month(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        if (mon == MONTH_FEB && leap)
        begin
            len = 5'd29;
        end
        days_in_month = len;
    endfunction

endpackage

// ----- hw/rtl/escal_in_if.sv -----
// Input channel: one epoch timestamp per beat.
interface escal_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ----- hw/rtl/escal_out_if.sv -----
// Output channel: one set of calendar fields per beat.
interface escal_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [7:0] year_since_1900;
    logic [2:0] day_of_week;
    logic [8:0] day_of_year;

    modport source (
        output valid, output second, output minute, output hour, output day_of_month,
        output month, output year_since_1900, output day_of_week, output day_of_year,
        input ready
    );
    modport sink (
        input valid, input second, input minute, input hour, input day_of_month,
        input month, input year_since_1900, input day_of_week, input day_of_year,
        output ready
    );
endinterface

// ----- hw/rtl/escal_alu.sv -----
// Shared subtract-and-compare unit used by the year and month loops.
module escal_alu (
    input  logic [escal_pkg::ALU_W-1:0] a,
    input  logic [escal_pkg::ALU_W-1:0] b,
    output logic [escal_pkg::ALU_W-1:0] diff,
    output logic                        ge
);
    logic borrow;

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign ge = ~borrow;
endmodule

// ----- hw/rtl/escal_seq.sv -----
// Sequencer: walks the division passes, the year loop and the month loop.
module escal_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               out_free,
    input  escal_pkg::status_t status,
    output escal_pkg::ctrl_t   ctrl,
    output logic               in_ready
);
    escal_pkg::state_t state_reg, state_next;
    logic [escal_pkg::STEP_W-1:0] step_reg, step_next;
    logic last_step;

    assign last_step = (step_reg == escal_pkg::DIV_LAST_STEP);

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            escal_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (start)
                begin
                    state_next = escal_pkg::ST_DIV_SEC;
                end
            end
            escal_pkg::ST_DIV_SEC, escal_pkg::ST_DIV_MIN,
            escal_pkg::ST_DIV_HOUR, escal_pkg::ST_DIV_WDAY:
            begin
                if (last_step)
                begin
                    step_next = '0;
                    unique case (state_reg)
                        escal_pkg::ST_DIV_SEC:  state_next = escal_pkg::ST_DIV_MIN;
                        escal_pkg::ST_DIV_MIN:  state_next = escal_pkg::ST_DIV_HOUR;
                        escal_pkg::ST_DIV_HOUR: state_next = escal_pkg::ST_DIV_WDAY;
                        default:                state_next = escal_pkg::ST_YEAR;
                    endcase
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            escal_pkg::ST_YEAR:
            begin
                if (!status.ge)
                begin
                    state_next = escal_pkg::ST_MONTH;
                end
            end
            escal_pkg::ST_MONTH:
            begin
                if (!status.ge)
                begin
                    state_next = escal_pkg::ST_FINISH;
                end
            end
            escal_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = escal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = escal_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl.state     = state_reg;
        ctrl.last_step = last_step;
        ctrl.load_out  = (state_reg == escal_pkg::ST_FINISH) && out_free;
        in_ready       = (state_reg == escal_pkg::ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= escal_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end
endmodule

// ----- hw/rtl/escal_datapath.sv -----
// Datapath: reciprocal-multiply division passes and the shared subtract-compare unit.
module escal_datapath (
    input  logic                 clk,
    input  logic                 start,
    input  logic [31:0]          epoch_seconds,
    input  escal_pkg::ctrl_t     ctrl,
    output escal_pkg::status_t   status,
    output escal_pkg::result_t   result
);
    localparam int W = escal_pkg::ALU_W;

    logic [escal_pkg::EPOCH_W-1:0]   num_reg;
    logic [2*escal_pkg::EPOCH_W-1:0] prod_reg;
    logic [W-1:0]                    days_reg;
    logic [5:0]                      sec_reg;
    logic [5:0]                      min_reg;
    logic [4:0]                      hour_reg;
    logic [2:0]                      wday_reg;
    logic [7:0]                      year_reg;
    logic [8:0]                      yday_reg;
    logic [3:0]                      mon_reg;
    logic [4:0]                      mday_reg;

    logic [W-1:0]                    alu_a, alu_b, alu_diff;
    logic                            alu_ge;
    logic [escal_pkg::EPOCH_W-1:0]   recip;
    logic [2*escal_pkg::EPOCH_W-1:0] mul_prod;
    logic [escal_pkg::EPOCH_W-1:0]   quot;
    logic [escal_pkg::REM_W-1:0]     divisor;
    logic [2*escal_pkg::REM_W-1:0]   quot_mul;
    logic [escal_pkg::REM_W-1:0]     rem;
    logic [W-1:0]                    wday_num;
    logic                            leap;

    escal_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    // reciprocal, divisor and quotient bits for the current division pass
    always_comb
    begin
        unique case (ctrl.state)
            escal_pkg::ST_DIV_SEC:
            begin
                recip   = escal_pkg::RECIP_60;
                divisor = escal_pkg::SEC_PER_MIN;
                quot    = {5'b0, prod_reg[63:37]};
            end
            escal_pkg::ST_DIV_MIN:
            begin
                recip   = escal_pkg::RECIP_60;
                divisor = escal_pkg::MIN_PER_HOUR;
                quot    = {5'b0, prod_reg[63:37]};
            end
            escal_pkg::ST_DIV_HOUR:
            begin
                recip   = escal_pkg::RECIP_24;
                divisor = escal_pkg::HOUR_PER_DAY;
                quot    = {4'b0, prod_reg[63:36]};
            end
            escal_pkg::ST_DIV_WDAY:
            begin
                recip   = escal_pkg::RECIP_7;
                divisor = escal_pkg::DAYS_PER_WEEK;
                quot    = prod_reg[50:19];
            end
            default:
            begin
                recip   = '0;
                divisor = '0;
                quot    = '0;
            end
        endcase
    end

    assign mul_prod = {{escal_pkg::EPOCH_W{1'b0}}, num_reg}
                    * {{escal_pkg::EPOCH_W{1'b0}}, recip};
    // remainder is below 64, so the low bits of n - q * d are enough
    assign quot_mul = {{escal_pkg::REM_W{1'b0}}, quot[escal_pkg::REM_W-1:0]}
                    * {{escal_pkg::REM_W{1'b0}}, divisor};
    assign rem      = num_reg[escal_pkg::REM_W-1:0] - quot_mul[escal_pkg::REM_W-1:0];
    assign wday_num = quot[W-1:0] + escal_pkg::WDAY_OFFSET;
    assign leap     = escal_pkg::is_leap(year_reg);

    always_comb
    begin
        alu_a = days_reg;
        unique case (ctrl.state)
            escal_pkg::ST_YEAR:
            begin
                alu_b = leap ? escal_pkg::DAYS_LEAP : escal_pkg::DAYS_YEAR;
            end
            escal_pkg::ST_MONTH:
            begin
                alu_b = {{(W-5){1'b0}}, escal_pkg::days_in_month(mon_reg, leap)};
            end
            default:                alu_b = '0;
        endcase
    end

    assign status.ge = alu_ge;

    always_ff @(posedge clk)
    begin
        unique case (ctrl.state)
            escal_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    num_reg <= epoch_seconds;
                end
            end
            escal_pkg::ST_DIV_SEC, escal_pkg::ST_DIV_MIN,
            escal_pkg::ST_DIV_HOUR, escal_pkg::ST_DIV_WDAY:
            begin
                if (!ctrl.last_step)
                begin
                    prod_reg <= mul_prod;
                end
                else
                begin
                    unique case (ctrl.state)
                        escal_pkg::ST_DIV_SEC:
                        begin
                            sec_reg <= rem;
                            num_reg <= quot;
                        end
                        escal_pkg::ST_DIV_MIN:
                        begin
                            min_reg <= rem;
                            num_reg <= quot;
                        end
                        escal_pkg::ST_DIV_HOUR:
                        begin
                            hour_reg <= rem[4:0];
                            days_reg <= quot[W-1:0];
                            num_reg  <= {{(escal_pkg::EPOCH_W-W){1'b0}}, wday_num};
                        end
                        default:
                        begin
                            wday_reg <= rem[2:0];
                            year_reg <= escal_pkg::YEAR_EPOCH;
                        end
                    endcase
                end
            end
            escal_pkg::ST_YEAR:
            begin
                if (alu_ge)
                begin
                    days_reg <= alu_diff;
                    year_reg <= year_reg + 8'd1;
                end
                else
                begin
                    yday_reg <= days_reg[8:0];
                    mon_reg  <= '0;
                end
            end
            escal_pkg::ST_MONTH:
            begin
                if (alu_ge)
                begin
                    days_reg <= alu_diff;
                    mon_reg  <= mon_reg + 4'd1;
                end
                else
                begin
                    mday_reg <= days_reg[4:0] + 5'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result.second          = sec_reg;
    assign result.minute          = min_reg;
    assign result.hour            = hour_reg;
    assign result.day_of_month    = mday_reg;
    assign result.month           = mon_reg;
    assign result.year_since_1900 = year_reg;
    assign result.day_of_week     = wday_reg;
    assign result.day_of_year     = yday_reg;
endmodule

// ----- hw/rtl/epoch_seconds_to_calendar_unit.sv -----
// Top level: unsigned epoch seconds to UTC calendar fields.
//
// in_ch carries one 32-bit seconds count per beat; out_ch returns one beat
// of calendar fields (second .. day of year) for every input beat, in order.
// in_ch.ready is high only while the sequencer is idle; one timestamp is in
// work at a time.
// The four division passes (by 60, 60, 24 and the weekday mod 7) each
// run a registered reciprocal multiply followed by a quotient and
// remainder step; the year loop then walks the whole years after 1970
// (0..136) and the month loop the month index (0..11), each running one
// subtraction a cycle through the shared 16-bit subtract-compare unit.
// Once the result is registered the sequencer returns to idle, where
// the next timestamp is accepted.
// The result sits in an output register; a new timestamp can be accepted
// while it waits. If the receiver still holds the previous result when the
// next one finishes, the sequencer waits until the slot frees.
// rst_n (asynchronous, active low) returns to idle and drops out_ch.valid.
module epoch_seconds_to_calendar_unit (
    input  logic              clk,
    input  logic              rst_n,
    escal_in_if.sink          in_ch,
    escal_out_if.source       out_ch
);
    escal_pkg::ctrl_t   ctrl;
    escal_pkg::status_t status;
    escal_pkg::result_t result;
    escal_pkg::result_t out_reg;
    logic               out_valid_reg;
    logic               out_free;
    logic               start;

    assign start    = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    escal_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .status   (status),
        .ctrl     (ctrl),
        .in_ready (in_ch.ready)
    );

    escal_datapath u_datapath (
        .clk           (clk),
        .start         (start),
        .epoch_seconds (in_ch.epoch_seconds),
        .ctrl          (ctrl),
        .status        (status),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_reg <= result;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.second          = out_reg.second;
    assign out_ch.minute          = out_reg.minute;
    assign out_ch.hour            = out_reg.hour;
    assign out_ch.day_of_month    = out_reg.day_of_month;
    assign out_ch.month           = out_reg.month;
    assign out_ch.year_since_1900 = out_reg.year_since_1900;
    assign out_ch.day_of_week     = out_reg.day_of_week;
    assign out_ch.day_of_year     = out_reg.day_of_year;
endmodule
